### design/clb_pkg.sv
// Shared types, codes and constants for the cursor list buffer.
package clb_pkg;

	localparam int CLB_CAPACITY   = 64;
	localparam int CLB_VALUE_BITS = 32;

	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 2;
	localparam int FIELD_W  = 32;
	localparam int POS_W    = 7;

	localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
	localparam logic [FUNC_W-1:0] FN_NEXT   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_PREV   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_HEAD   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_DELETE = 3'd4;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_EDGE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_REPORT
	} state_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH,
		OP_POP,
		OP_REPLACE,
		OP_WRITE
	} stack_op_t;

	typedef struct packed {
		stack_op_t l_op;
		stack_op_t r_op;
	} cell_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic signed [FIELD_W-1:0] item_value;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [FIELD_W-1:0] cursor_value;
		logic [POS_W-1:0]          cursor_position;
		logic [POS_W-1:0]          element_count;
		logic                      at_head;
		logic                      at_tail;
	} rsp_t;

endpackage

### design/clb_cell.sv
// One cell of the two-stack chain: a slot of the left stack and a slot of the right stack.
module clb_cell #(
	parameter int IDX_W      = 6,
	parameter int VALUE_BITS = 32,
	parameter int IDX        = 0
) (
	input  logic                   clk,
	input  clb_pkg::cell_cmd_t     cmd,
	input  logic [IDX_W-1:0]       wr_idx,
	input  logic [VALUE_BITS-1:0]  l_prev,
	input  logic [VALUE_BITS-1:0]  l_next,
	input  logic [VALUE_BITS-1:0]  r_prev,
	input  logic [VALUE_BITS-1:0]  r_next,
	input  logic [VALUE_BITS-1:0]  r_wval,
	output logic [VALUE_BITS-1:0]  l_q,
	output logic [VALUE_BITS-1:0]  r_q
);
	import clb_pkg::*;

	always_ff @(posedge clk) begin
		unique case (cmd.l_op)
			OP_PUSH: l_q <= l_prev;
			OP_POP: l_q <= l_next;
			OP_REPLACE: begin
				if (IDX == 0) begin
					l_q <= l_prev;
				end
			end
			default: begin
			end
		endcase
		unique case (cmd.r_op)
			OP_PUSH: r_q <= r_prev;
			OP_POP: r_q <= r_next;
			OP_WRITE: begin
				if (wr_idx == IDX_W'(IDX)) begin
					r_q <= r_wval;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### design/clb_ctrl.sv
// Command sequencer, stack depth counters and result register of the cursor list buffer.
module clb_ctrl #(
	parameter int CAPACITY   = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  clb_pkg::cmd_t                  cmd,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output clb_pkg::rsp_t                  rsp,
	input  logic [VALUE_BITS-1:0]          l_top,
	input  logic [VALUE_BITS-1:0]          r_top,
	output clb_pkg::cell_cmd_t             cell_cmd,
	output logic [VALUE_BITS-1:0]          l_din,
	output logic [VALUE_BITS-1:0]          r_din,
	output logic [$clog2(CAPACITY)-1:0]    wr_idx
);
	import clb_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	state_t                state_q, state_d;
	status_t               status_q, status_d;
	logic [CNT_W-1:0]      lcount_q, lcount_d;
	logic [CNT_W-1:0]      rcount_q, rcount_d;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;
	logic                  load;
	logic                  empty;
	logic [CNT_W-1:0]      total;
	logic [VALUE_BITS-1:0] fit;

	assign empty  = (lcount_q == '0);
	assign total  = CNT_W'(lcount_q + rcount_q);
	assign fit    = VALUE_BITS'(cmd.item_value);
	assign wr_idx = rcount_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_DONE;
			lcount_q    <= '0;
			rcount_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			lcount_q <= lcount_d;
			rcount_q <= rcount_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.status          <= status_q;
			rsp_q.cursor_value    <= empty ? '0 : FIELD_W'(signed'(l_top));
			rsp_q.cursor_position <= POS_W'(lcount_q);
			rsp_q.element_count   <= POS_W'(total);
			rsp_q.at_head         <= (lcount_q == CNT_W'(1));
			rsp_q.at_tail         <= !empty && (rcount_q == '0);
		end
	end

	always_comb begin
		state_d       = state_q;
		status_d      = status_q;
		lcount_d      = lcount_q;
		rcount_d      = rcount_q;
		cell_cmd.l_op = OP_HOLD;
		cell_cmd.r_op = OP_HOLD;
		l_din         = r_top;
		r_din         = l_top;
		load          = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					status_d = ST_DONE;
					state_d  = S_REPORT;
					unique case (cmd.func)
						FN_APPEND: begin
							if (total >= CNT_W'(CAPACITY)) begin
								status_d = ST_FULL;
							end else if (empty) begin
								cell_cmd.l_op = OP_PUSH;
								l_din         = fit;
								lcount_d      = CNT_W'(1);
							end else begin
								cell_cmd.r_op = OP_WRITE;
								r_din         = fit;
								rcount_d      = rcount_q + CNT_W'(1);
							end
						end
						FN_NEXT: begin
							if (empty) begin
								status_d = ST_EMPTY;
							end else if (rcount_q == '0) begin
								status_d = ST_EDGE;
							end else begin
								cell_cmd.l_op = OP_PUSH;
								cell_cmd.r_op = OP_POP;
								lcount_d      = lcount_q + CNT_W'(1);
								rcount_d      = rcount_q - CNT_W'(1);
							end
						end
						FN_PREV: begin
							if (empty) begin
								status_d = ST_EMPTY;
							end else if (lcount_q == CNT_W'(1)) begin
								status_d = ST_EDGE;
							end else begin
								cell_cmd.l_op = OP_POP;
								cell_cmd.r_op = OP_PUSH;
								lcount_d      = lcount_q - CNT_W'(1);
								rcount_d      = rcount_q + CNT_W'(1);
							end
						end
						FN_HEAD: begin
							if (empty) begin
								status_d = ST_EMPTY;
							end else begin
								state_d = S_WALK;
							end
						end
						FN_DELETE: begin
							if (empty) begin
								status_d = ST_EMPTY;
							end else if (total == CNT_W'(1)) begin
								cell_cmd.l_op = OP_POP;
								lcount_d      = '0;
							end else if (lcount_q == CNT_W'(1)) begin
								cell_cmd.l_op = OP_REPLACE;
								cell_cmd.r_op = OP_POP;
								rcount_d      = rcount_q - CNT_W'(1);
							end else begin
								cell_cmd.l_op = OP_POP;
								lcount_d      = lcount_q - CNT_W'(1);
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_WALK: begin
				if (lcount_q > CNT_W'(1)) begin
					cell_cmd.l_op = OP_POP;
					cell_cmd.r_op = OP_PUSH;
					lcount_d      = lcount_q - CNT_W'(1);
					rcount_d      = rcount_q + CNT_W'(1);
				end else begin
					state_d = S_REPORT;
				end
			end
			S_REPORT: begin
				if (!rsp_valid_q || rsp_ready) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### design/cursor_list_buffer_core.sv
// Cursor list buffer: a row of two-stack cells split at the cursor, run by a command sequencer.
// Results load in the report state when the result register is free; to-head walks first.
// New commands wait for the last result to load; to-head walks the cursor back one cell a cycle.
// The left stack top is the cursor element, so every result reads one fixed cell.
// Reset clears the sequencer, the stack depths and the result valid; cell storage is not reset.
module cursor_list_buffer_core #(
	parameter int CAPACITY   = clb_pkg::CLB_CAPACITY,
	parameter int VALUE_BITS = clb_pkg::CLB_VALUE_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  clb_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output clb_pkg::rsp_t rsp
);
	import clb_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);

	cell_cmd_t             cell_cmd;
	logic [VALUE_BITS-1:0] l_din;
	logic [VALUE_BITS-1:0] r_din;
	logic [IDX_W-1:0]      wr_idx;
	logic [VALUE_BITS-1:0] l_q [CAPACITY];
	logic [VALUE_BITS-1:0] r_q [CAPACITY];

	clb_ctrl #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.l_top     (l_q[0]),
		.r_top     (r_q[0]),
		.cell_cmd  (cell_cmd),
		.l_din     (l_din),
		.r_din     (r_din),
		.wr_idx    (wr_idx)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_BITS-1:0] l_prev, l_next, r_prev, r_next;

		if (i == 0) begin : g_first
			assign l_prev = l_din;
			assign r_prev = r_din;
		end else begin : g_inner_prev
			assign l_prev = l_q[i-1];
			assign r_prev = r_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign l_next = l_q[i];
			assign r_next = r_q[i];
		end else begin : g_inner_next
			assign l_next = l_q[i+1];
			assign r_next = r_q[i+1];
		end

		clb_cell #(
			.IDX_W      (IDX_W),
			.VALUE_BITS (VALUE_BITS),
			.IDX        (i)
		) u_cell (
			.clk    (clk),
			.cmd    (cell_cmd),
			.wr_idx (wr_idx),
			.l_prev (l_prev),
			.l_next (l_next),
			.r_prev (r_prev),
			.r_next (r_next),
			.r_wval (r_din),
			.l_q    (l_q[i]),
			.r_q    (r_q[i])
		);
	end

`ifndef ASSERT_OFF
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("A second command was taken while one was in progress.");

	a_empty_view: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_EMPTY) |->
		(rsp.cursor_position == '0 && rsp.element_count == '0 && !rsp.at_head && !rsp.at_tail))
		else $error("An empty-list result reports a cursor or elements.");
`endif

endmodule
